// File: rtl/rpfe_pkg.sv
// Shared types, constants and digit helpers for the RMC position field extractor.
package rpfe_pkg;

   localparam int SentenceLengthDefault = 70;
   localparam int SecPerMin             = 60;

   typedef logic [7:0]  pos_type;
   typedef logic [7:0]  char_type;
   typedef logic [13:0] acc_type;

   localparam char_type StartChar = 8'h24;
   localparam char_type TypeChar  = 8'h52;
   localparam char_type DotChar   = 8'h2E;
   localparam char_type ZeroChar  = 8'h30;
   localparam char_type NineChar  = 8'h39;

   localparam pos_type TypePos    = 8'd3;
   localparam pos_type LatDegPos  = 8'd20;
   localparam pos_type LatMinPos  = 8'd22;
   localparam pos_type LatFracPos = 8'd24;
   localparam pos_type LatFracEnd = 8'd29;
   localparam pos_type LonDegPos  = 8'd32;
   localparam pos_type LonMinPos  = 8'd35;
   localparam pos_type LonFracPos = 8'd37;
   localparam pos_type LonFracEnd = 8'd42;

   // bit positions in the field-stopped flags
   localparam int StopLatDeg  = 0;
   localparam int StopLatMin  = 1;
   localparam int StopLatFrac = 2;
   localparam int StopLonDeg  = 3;
   localparam int StopLonMin  = 4;
   localparam int StopLonFrac = 5;

   typedef struct packed {
      logic [6:0]  lat_deg;
      logic [6:0]  lat_min;
      logic [19:0] lat_seconds_e4;
      logic [9:0]  lon_degrees;
      logic [6:0]  lon_minutes;
      logic [19:0] lon_seconds_e4;
   } fix_type;

   typedef struct packed {
      logic emit;      // accepted beat closes an RMC sentence
      logic term_rmc;  // next captured beat would close an RMC sentence
   } parse_status_type;

   function automatic logic is_digit(input char_type c);
      return (c >= ZeroChar) && (c <= NineChar);
   endfunction

   // acc * 10 + digit, wrapping at the accumulator width
   function automatic acc_type dec_step(input acc_type acc, input char_type c);
      acc_type sum;
      sum = (acc << 3) + (acc << 1) + acc_type'(c[3:0]);
      return sum;
   endfunction

endpackage

// File: rtl/rmc_position_field_extractor.sv
// Top level of the RMC position field extractor.
//
//   port group   dir   handshake                payload
//   req_*        in    req_valid / req_ready    req_rx_byte
//   rsp_*        out   rsp_valid / rsp_ready    lat/lon degrees, minutes, seconds_e4
//
// One byte is taken per cycle while req_ready is high; parser state updates
// at the accepting edge. A result beat appears in the result register in the
// cycle after the byte that closes an RMC sentence (position SENTENCE_LENGTH-1).
// Reset clears capture state and the result valid; no clearing pass is needed.
// req_ready drops only when the closing byte of an RMC sentence is next and the
// result register still holds an untaken beat; otherwise bytes flow on stalls.
module rmc_position_field_extractor #(
   parameter int SENTENCE_LENGTH = rpfe_pkg::SentenceLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_lat_deg,
   output logic [6:0]  rsp_lat_min,
   output logic [19:0] rsp_lat_seconds_e4,
   output logic [9:0]  rsp_lon_degrees,
   output logic [6:0]  rsp_lon_minutes,
   output logic [19:0] rsp_lon_seconds_e4
);
   import rpfe_pkg::*;

   parse_status_type status;
   fix_type          fix_next;
   fix_type          fix_out;
   logic             accept;

   assign req_ready = !(rsp_valid && !rsp_ready && status.term_rmc);
   assign accept    = req_valid && req_ready;

   rpfe_parser #(
      .SENTENCE_LENGTH(SENTENCE_LENGTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .status  (status),
      .fix     (fix_next)
   );

   rpfe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (status.emit),
      .fix_in    (fix_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .fix_out   (fix_out)
   );

   assign rsp_lat_deg        = fix_out.lat_deg;
   assign rsp_lat_min        = fix_out.lat_min;
   assign rsp_lat_seconds_e4 = fix_out.lat_seconds_e4;
   assign rsp_lon_degrees    = fix_out.lon_degrees;
   assign rsp_lon_minutes    = fix_out.lon_minutes;
   assign rsp_lon_seconds_e4 = fix_out.lon_seconds_e4;

endmodule

// File: rtl/rpfe_parser.sv
// Sentence position tracking and fixed-offset field accumulation.
module rpfe_parser #(
   parameter int SENTENCE_LENGTH = rpfe_pkg::SentenceLengthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  rpfe_pkg::char_type          rx_byte,
   output rpfe_pkg::parse_status_type  status,
   output rpfe_pkg::fix_type           fix
);
   import rpfe_pkg::*;

   localparam pos_type LastPos = pos_type'(SENTENCE_LENGTH - 1);

   logic       capturing_ff, capturing_in;
   logic       rmc_ff, rmc_in;
   pos_type    pos_ff, pos_in;
   logic [5:0] stop_ff, stop_in;
   logic [6:0] lat_deg_ff, lat_deg_in;
   logic [6:0] lat_min_ff, lat_min_in;
   acc_type    lat_frac_ff, lat_frac_in;
   logic [9:0] lon_deg_ff, lon_deg_in;
   logic [6:0] lon_min_ff, lon_min_in;
   acc_type    lon_frac_ff, lon_frac_in;
   logic       at_last;
   logic       emit;
   logic       digit;

   assign at_last = pos_ff >= LastPos;
   assign digit   = is_digit(rx_byte);

   always_comb begin
      capturing_in = capturing_ff;
      rmc_in       = rmc_ff;
      pos_in       = pos_ff;
      stop_in      = stop_ff;
      lat_deg_in   = lat_deg_ff;
      lat_min_in   = lat_min_ff;
      lat_frac_in  = lat_frac_ff;
      lon_deg_in   = lon_deg_ff;
      lon_min_in   = lon_min_ff;
      lon_frac_in  = lon_frac_ff;
      emit         = 1'b0;
      if (accept) begin
         if (!capturing_ff) begin
            if (rx_byte == StartChar) begin
               // start char sits at position 0, nothing parsed there
               capturing_in = 1'b1;
               pos_in       = pos_type'(1);
               rmc_in       = 1'b0;
               stop_in      = '0;
               lat_deg_in   = '0;
               lat_min_in   = '0;
               lat_frac_in  = '0;
               lon_deg_in   = '0;
               lon_min_in   = '0;
               lon_frac_in  = '0;
            end
         end else if (at_last) begin
            // terminating beat is dropped
            emit         = rmc_ff;
            capturing_in = 1'b0;
            pos_in       = '0;
         end else begin
            pos_in = pos_ff + pos_type'(1);
            if (pos_ff == TypePos) begin
               rmc_in = (rx_byte == TypeChar);
            end
            if (pos_ff >= LatDegPos && pos_ff < LatMinPos) begin
               if (!stop_ff[StopLatDeg]) begin
                  if (digit) lat_deg_in = 7'(dec_step(acc_type'(lat_deg_ff), rx_byte));
                  else       stop_in[StopLatDeg] = 1'b1;
               end
            end else if (pos_ff >= LatMinPos && pos_ff < LatFracPos) begin
               if (!stop_ff[StopLatMin]) begin
                  if (digit) lat_min_in = 7'(dec_step(acc_type'(lat_min_ff), rx_byte));
                  else       stop_in[StopLatMin] = 1'b1;
               end
            end else if (pos_ff >= LatFracPos && pos_ff < LatFracEnd) begin
               if (pos_ff == LatFracPos) begin
                  if (rx_byte != DotChar) stop_in[StopLatFrac] = 1'b1;
               end else if (!stop_ff[StopLatFrac] && digit) begin
                  lat_frac_in = dec_step(lat_frac_ff, rx_byte);
               end else begin
                  stop_in[StopLatFrac] = 1'b1;
                  lat_frac_in          = dec_step(lat_frac_ff, ZeroChar);
               end
            end else if (pos_ff >= LonDegPos && pos_ff < LonMinPos) begin
               if (!stop_ff[StopLonDeg]) begin
                  if (digit) lon_deg_in = 10'(dec_step(acc_type'(lon_deg_ff), rx_byte));
                  else       stop_in[StopLonDeg] = 1'b1;
               end
            end else if (pos_ff >= LonMinPos && pos_ff < LonFracPos) begin
               if (!stop_ff[StopLonMin]) begin
                  if (digit) lon_min_in = 7'(dec_step(acc_type'(lon_min_ff), rx_byte));
                  else       stop_in[StopLonMin] = 1'b1;
               end
            end else if (pos_ff >= LonFracPos && pos_ff < LonFracEnd) begin
               if (pos_ff == LonFracPos) begin
                  if (rx_byte != DotChar) stop_in[StopLonFrac] = 1'b1;
               end else if (!stop_ff[StopLonFrac] && digit) begin
                  lon_frac_in = dec_step(lon_frac_ff, rx_byte);
               end else begin
                  stop_in[StopLonFrac] = 1'b1;
                  lon_frac_in          = dec_step(lon_frac_ff, ZeroChar);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         rmc_ff       <= 1'b0;
         pos_ff       <= '0;
         stop_ff      <= '0;
         lat_deg_ff   <= '0;
         lat_min_ff   <= '0;
         lat_frac_ff  <= '0;
         lon_deg_ff   <= '0;
         lon_min_ff   <= '0;
         lon_frac_ff  <= '0;
      end else begin
         capturing_ff <= capturing_in;
         rmc_ff       <= rmc_in;
         pos_ff       <= pos_in;
         stop_ff      <= stop_in;
         lat_deg_ff   <= lat_deg_in;
         lat_min_ff   <= lat_min_in;
         lat_frac_ff  <= lat_frac_in;
         lon_deg_ff   <= lon_deg_in;
         lon_min_ff   <= lon_min_in;
         lon_frac_ff  <= lon_frac_in;
      end
   end

   assign status.emit     = emit;
   assign status.term_rmc = capturing_ff && at_last && rmc_ff;

   // seconds * 1e4 = 60 * four fraction digits
   assign fix.lat_deg        = lat_deg_ff;
   assign fix.lat_min        = lat_min_ff;
   assign fix.lat_seconds_e4 = 20'(lat_frac_ff) * 20'(SecPerMin);
   assign fix.lon_degrees    = lon_deg_ff;
   assign fix.lon_minutes    = lon_min_ff;
   assign fix.lon_seconds_e4 = 20'(lon_frac_ff) * 20'(SecPerMin);

   a_emit_ends_capture : assert property (@(posedge clock) disable iff (reset)
      emit |=> !capturing_ff)
      else $error("capture still open after result beat");

   a_idle_pos_zero : assert property (@(posedge clock) disable iff (reset)
      !capturing_ff |-> pos_ff == '0)
      else $error("position nonzero while idle");

   a_capture_pos_range : assert property (@(posedge clock) disable iff (reset)
      capturing_ff |-> (pos_ff != '0) && (pos_ff <= LastPos))
      else $error("position out of range during capture");

endmodule

// File: rtl/rpfe_out_reg.sv
// Result register holding one fix beat until the consumer takes it.
module rpfe_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rpfe_pkg::fix_type  fix_in,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output rpfe_pkg::fix_type  fix_out
);
   import rpfe_pkg::*;

   logic    valid_ff, valid_in;
   fix_type fix_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load)                       valid_in = 1'b1;
      else if (valid_ff && rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fix_ff <= fix_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign fix_out   = fix_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> !(valid_ff && !rsp_ready))
      else $error("result beat overwritten before it was taken");

endmodule
